// ----- sv/cbq_pkg.sv -----
// Shared widths, register indexes, reset values and types of the biquad cascade.
package cbq_pkg;

    localparam int unsigned ACC_W      = 64;
    localparam int unsigned GAIN_W     = 40;
    localparam int unsigned COEF_W     = 32;
    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned OUT_W      = 32;
    localparam int unsigned MUL_W      = 32;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 40;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FB1_ONE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FB1_TWO      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FB2_ONE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FB2_TWO      = 3'd4;

    // Command codes
    localparam logic CMD_FILTER = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // Register reset values (gain Q0.40, feedback Q2.30)
    localparam logic [GAIN_W-1:0]        GAIN_RESET    = 40'd1038700;
    localparam logic signed [COEF_W-1:0] FB1_ONE_RESET = -32'sd2144112099;
    localparam logic signed [COEF_W-1:0] FB1_TWO_RESET = 32'sd1070374570;
    localparam logic signed [COEF_W-1:0] FB2_ONE_RESET = -32'sd2145800021;
    localparam logic signed [COEF_W-1:0] FB2_TWO_RESET = 32'sd1072062492;

    // Saturation bounds of a Q31.32 value
    localparam logic [ACC_W-1:0] SAT_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] SAT_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // Half an LSB when dropping 30 fraction bits
    localparam logic [ACC_W-1:0] RND_Q30 = 64'h0000_0000_2000_0000;

    // Result of the saturating adder
    typedef struct packed {
        logic [ACC_W-1:0] value;
        logic             ovf;
    } t_sat_res;

endpackage

// ----- sv/cbq_sat_addsub.sv -----
// Shared 64-bit saturating adder/subtractor of the biquad cascade.
module cbq_sat_addsub (
    input  logic [cbq_pkg::ACC_W-1:0] i_a,
    input  logic [cbq_pkg::ACC_W-1:0] i_b,
    input  logic                      i_sub,
    output cbq_pkg::t_sat_res         o_res
);
    import cbq_pkg::*;

    logic [ACC_W-1:0] b_eff;
    logic [ACC_W-1:0] sum;
    logic             ovf;

    // One carry chain: subtract as add of the inverted operand plus one
    always_comb begin
        b_eff = i_sub ? ~i_b : i_b;
        sum   = i_a + b_eff + {{(ACC_W-1){1'b0}}, i_sub};
        ovf   = (i_a[ACC_W-1] == b_eff[ACC_W-1]) && (sum[ACC_W-1] != i_a[ACC_W-1]);
        o_res.ovf   = ovf;
        o_res.value = ovf ? (i_a[ACC_W-1] ? SAT_MIN : SAT_MAX) : sum;
    end

endmodule

// ----- sv/cascaded_biquad_lowpass_core.sv -----
// Top level of the two-section fixed-point biquad low-pass cascade (DF2T).
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------
//  in      | input     | i_valid / o_stall  | i_cmd, i_sample_in
//  out     | output    | o_valid / i_stall  | o_filtered_sample, o_saturated
//  cfg     | input     | i_cfg_we           | i_cfg_index, i_cfg_data
//
// A filter transaction runs through the gain, scale, per-section and output states
// before its result is loaded, and the next transaction is taken only back in idle;
// the single 32x32 multiplier and the shared saturating adder set this.
// A clear transaction zeroes the delay states in the accepting cycle.
// Reset is synchronous and active low; it restores the registers and zeroes
// the delay states. A stalled result stays in the output register while the
// next input transaction is already being worked on.
module cascaded_biquad_lowpass_core #(
    parameter int SECTIONS = 2
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic                                   i_cmd,
    input  logic signed [cbq_pkg::SAMPLE_W-1:0]    i_sample_in,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [cbq_pkg::OUT_W-1:0]       o_filtered_sample,
    output logic                                   o_saturated,
    input  logic                                   i_cfg_we,
    input  logic [cbq_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [cbq_pkg::CFG_DATA_W-1:0]         i_cfg_data
);
    import cbq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GAIN_LO,
        S_GAIN_HI,
        S_GAIN_SUM,
        S_SCALE,
        S_SEC_IN,
        S_Y,
        S_Y_MAG,
        S_MUL_A,
        S_MUL_B,
        S_MUL_C,
        S_MUL_D,
        S_UPD_ONE,
        S_UPD_TWO,
        S_OUT
    } t_state;

    t_state r_state;

    // Configuration registers
    logic [GAIN_W-1:0] r_gain;
    logic [COEF_W-1:0] r_fb1_one;
    logic [COEF_W-1:0] r_fb1_two;
    logic [COEF_W-1:0] r_fb2_one;
    logic [COEF_W-1:0] r_fb2_two;

    // Delay states, one pair per section
    logic [ACC_W-1:0] r_d1 [SECTIONS];
    logic [ACC_W-1:0] r_d2 [SECTIONS];

    // Datapath registers
    logic                r_sec;
    logic                r_xneg;
    logic [SAMPLE_W-1:0] r_xmag;
    logic [2*MUL_W-1:0]  r_prod;
    logic [ACC_W-1:0]    r_acc;
    logic [ACC_W-1:0]    r_bx0;
    logic [ACC_W-1:0]    r_bx1;
    logic [ACC_W-1:0]    r_y;
    logic [ACC_W-1:0]    r_ymag;
    logic [COEF_W-1:0]   r_a1mag;
    logic [COEF_W-1:0]   r_a2mag;
    logic [ACC_W-1:0]    r_p;
    logic [ACC_W-1:0]    r_t;
    logic                r_flag;

    // Output register
    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out_sample;
    logic                r_out_sat;

    logic [SAMPLE_W-1:0] samp_u;
    logic [SAMPLE_W-1:0] x_mag;
    logic [COEF_W-1:0]   a1_sel;
    logic [COEF_W-1:0]   a2_sel;
    logic [ACC_W-1:0]    d1_sel;
    logic [ACC_W-1:0]    d2_sel;
    logic [MUL_W-1:0]    mul_a;
    logic [MUL_W-1:0]    mul_b;
    logic                comb_neg;
    logic [ACC_W+1:0]    m_full;
    logic [ACC_W+1:0]    m_limit;
    logic                comb_ovf;
    logic [ACC_W-1:0]    m_sat;
    logic [ACC_W-1:0]    comb_val;
    logic [SAMPLE_W+GAIN_W:0]   bx0_sum;
    logic [SAMPLE_W+GAIN_W+1:0] bx1_sum;
    logic [ACC_W-1:0]    bx0_mag;
    logic [ACC_W-1:0]    bx1_mag;
    logic [ACC_W-1:0]    add_a;
    logic [ACC_W-1:0]    add_b;
    logic                add_sub;
    t_sat_res            sat_res;

    assign o_stall           = (r_state != S_IDLE);
    assign o_valid           = r_out_valid;
    assign o_filtered_sample = r_out_sample;
    assign o_saturated       = r_out_sat;

    // Magnitude of the incoming sample (covers the most negative code)
    assign samp_u = i_sample_in;
    assign x_mag  = samp_u[SAMPLE_W-1] ? (~samp_u + 1'b1) : samp_u;

    // Select coefficients and delay states of the active section
    assign a1_sel = r_sec ? r_fb2_one : r_fb1_one;
    assign a2_sel = r_sec ? r_fb2_two : r_fb1_two;
    assign d1_sel = r_sec ? r_d1[SECTIONS-1] : r_d1[0];
    assign d2_sel = r_sec ? r_d2[SECTIONS-1] : r_d2[0];

    // Multiplier operand selection
    always_comb begin
        case (r_state)
            S_GAIN_LO: begin
                mul_a = {{(MUL_W-SAMPLE_W){1'b0}}, r_xmag};
                mul_b = r_gain[MUL_W-1:0];
            end
            S_GAIN_HI: begin
                mul_a = {{(MUL_W-SAMPLE_W){1'b0}}, r_xmag};
                mul_b = {{(2*MUL_W-GAIN_W){1'b0}}, r_gain[GAIN_W-1:MUL_W]};
            end
            S_MUL_A: begin
                mul_a = r_ymag[MUL_W-1:0];
                mul_b = r_a1mag;
            end
            S_MUL_B: begin
                mul_a = r_ymag[ACC_W-1:MUL_W];
                mul_b = r_a1mag;
            end
            S_MUL_C: begin
                mul_a = r_ymag[MUL_W-1:0];
                mul_b = r_a2mag;
            end
            S_MUL_D: begin
                mul_a = r_ymag[ACC_W-1:MUL_W];
                mul_b = r_a2mag;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Assemble coefficient product: Q.62 down to Q.32, round, clamp, apply sign
    always_comb begin
        comb_neg = ((r_state == S_UPD_ONE) ? a2_sel[COEF_W-1] : a1_sel[COEF_W-1])
                   ^ r_y[ACC_W-1];
        m_full   = {r_prod, 2'b00} + {32'b0, r_acc[ACC_W-1:30]};
        m_limit  = comb_neg ? {2'b00, SAT_MIN} : {2'b00, SAT_MAX};
        comb_ovf = (m_full > m_limit);
        m_sat    = comb_ovf ? m_limit[ACC_W-1:0] : m_full[ACC_W-1:0];
        comb_val = comb_neg ? (~m_sat + 1'b1) : m_sat;
    end

    // Round the gain product from Q.40 to Q.32, once and twice the sample
    always_comb begin
        bx0_sum = {1'b0, r_acc[SAMPLE_W+GAIN_W-1:0]} + 57'd128;
        bx1_sum = {1'b0, r_acc[SAMPLE_W+GAIN_W-1:0], 1'b0} + 58'd128;
        bx0_mag = {15'b0, bx0_sum[SAMPLE_W+GAIN_W:8]};
        bx1_mag = {14'b0, bx1_sum[SAMPLE_W+GAIN_W+1:8]};
    end

    // Shared saturating adder operand selection
    always_comb begin
        case (r_state)
            S_Y: begin
                add_a = r_bx0;  add_b = d1_sel; add_sub = 1'b0;
            end
            S_MUL_D: begin
                add_a = r_bx1;  add_b = r_p;    add_sub = 1'b1;
            end
            S_UPD_ONE: begin
                add_a = r_t;    add_b = d2_sel; add_sub = 1'b0;
            end
            S_UPD_TWO: begin
                add_a = r_bx0;  add_b = r_p;    add_sub = 1'b1;
            end
            S_SEC_IN: begin
                add_a = r_y;    add_b = r_y;    add_sub = 1'b0;
            end
            default: begin
                add_a = r_bx0;  add_b = d1_sel; add_sub = 1'b0;
            end
        endcase
    end

    cbq_sat_addsub u_addsub (
        .i_a   (add_a),
        .i_b   (add_b),
        .i_sub (add_sub),
        .o_res (sat_res)
    );

    // Sequencer, datapath registers and output register
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sec       <= 1'b0;
            r_flag      <= 1'b0;
            r_out_valid <= 1'b0;
            r_gain      <= GAIN_RESET;
            r_fb1_one   <= FB1_ONE_RESET;
            r_fb1_two   <= FB1_TWO_RESET;
            r_fb2_one   <= FB2_ONE_RESET;
            r_fb2_two   <= FB2_TWO_RESET;
            for (int s = 0; s < SECTIONS; s++) begin
                r_d1[s] <= '0;
                r_d2[s] <= '0;
            end
        end else begin
            // Drop the result once the consumer takes it
            if (r_out_valid && !i_stall && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end

            // Configuration writes; unknown indexes are ignored
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_INPUT_GAIN: r_gain    <= i_cfg_data;
                    CFG_FB1_ONE:    r_fb1_one <= i_cfg_data[COEF_W-1:0];
                    CFG_FB1_TWO:    r_fb1_two <= i_cfg_data[COEF_W-1:0];
                    CFG_FB2_ONE:    r_fb2_one <= i_cfg_data[COEF_W-1:0];
                    CFG_FB2_TWO:    r_fb2_two <= i_cfg_data[COEF_W-1:0];
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_cmd == CMD_CLEAR) begin
                            for (int s = 0; s < SECTIONS; s++) begin
                                r_d1[s] <= '0;
                                r_d2[s] <= '0;
                            end
                        end else begin
                            r_xneg  <= i_sample_in[SAMPLE_W-1];
                            r_xmag  <= x_mag;
                            r_sec   <= 1'b0;
                            r_flag  <= 1'b0;
                            r_state <= S_GAIN_LO;
                        end
                    end
                end
                S_GAIN_LO: begin
                    r_state <= S_GAIN_HI;
                end
                S_GAIN_HI: begin
                    r_acc   <= r_prod;
                    r_state <= S_GAIN_SUM;
                end
                S_GAIN_SUM: begin
                    r_acc   <= r_acc + {r_prod[MUL_W-1:0], 32'b0};
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_bx0   <= r_xneg ? (~bx0_mag + 1'b1) : bx0_mag;
                    r_bx1   <= r_xneg ? (~bx1_mag + 1'b1) : bx1_mag;
                    r_state <= S_Y;
                end
                S_SEC_IN: begin
                    r_bx0   <= r_y;
                    r_bx1   <= sat_res.value;
                    r_flag  <= r_flag | sat_res.ovf;
                    r_state <= S_Y;
                end
                S_Y: begin
                    r_y     <= sat_res.value;
                    r_flag  <= r_flag | sat_res.ovf;
                    r_state <= S_Y_MAG;
                end
                S_Y_MAG: begin
                    r_ymag  <= r_y[ACC_W-1] ? (~r_y + 1'b1) : r_y;
                    r_a1mag <= a1_sel[COEF_W-1] ? (~a1_sel + 1'b1) : a1_sel;
                    r_a2mag <= a2_sel[COEF_W-1] ? (~a2_sel + 1'b1) : a2_sel;
                    r_state <= S_MUL_A;
                end
                S_MUL_A: begin
                    r_state <= S_MUL_B;
                end
                S_MUL_B: begin
                    r_acc   <= r_prod + RND_Q30;
                    r_state <= S_MUL_C;
                end
                S_MUL_C: begin
                    r_p     <= comb_val;
                    r_flag  <= r_flag | comb_ovf;
                    r_state <= S_MUL_D;
                end
                S_MUL_D: begin
                    r_acc   <= r_prod + RND_Q30;
                    r_t     <= sat_res.value;
                    r_flag  <= r_flag | sat_res.ovf;
                    r_state <= S_UPD_ONE;
                end
                S_UPD_ONE: begin
                    r_p    <= comb_val;
                    r_flag <= r_flag | comb_ovf | sat_res.ovf;
                    for (int s = 0; s < SECTIONS; s++) begin
                        if (r_sec == 1'(s)) begin
                            r_d1[s] <= sat_res.value;
                        end
                    end
                    r_state <= S_UPD_TWO;
                end
                S_UPD_TWO: begin
                    r_flag <= r_flag | sat_res.ovf;
                    for (int s = 0; s < SECTIONS; s++) begin
                        if (r_sec == 1'(s)) begin
                            r_d2[s] <= sat_res.value;
                        end
                    end
                    if (r_sec == 1'(SECTIONS - 1)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_sec   <= 1'b1;
                        r_state <= S_SEC_IN;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid  <= 1'b1;
                        r_out_sample <= r_y[ACC_W-1:ACC_W-OUT_W];
                        r_out_sat    <= r_flag;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- sv/cbq_checker.sv -----
// Port-level checks of the biquad cascade core, bound to the top level.
module cbq_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              i_in_stall,
    input logic                              i_cmd,
    input logic                              i_out_valid,
    input logic                              i_stall,
    input logic signed [cbq_pkg::OUT_W-1:0]  i_filtered_sample,
    input logic                              i_saturated
);
    import cbq_pkg::*;

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // A filter transaction occupies the core in the next cycle
    a_filter_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_in_stall && i_cmd == CMD_FILTER) |=> i_in_stall)
        else $error("core ready right after a filter transaction");

    // A clear transaction completes in place and leaves the core ready
    a_clear_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_in_stall && i_cmd == CMD_CLEAR) |=> !i_in_stall)
        else $error("clear transaction held the core");

    // A new result appears only at the end of a busy period
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_stall))
        else $error("result without work");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_stall) |=>
            (i_out_valid && $stable(i_filtered_sample) && $stable(i_saturated)))
        else $error("stalled result changed");

endmodule

bind cascaded_biquad_lowpass_core cbq_checker u_cbq_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .i_in_stall        (o_stall),
    .i_cmd             (i_cmd),
    .i_out_valid       (o_valid),
    .i_stall           (i_stall),
    .i_filtered_sample (o_filtered_sample),
    .i_saturated       (o_saturated)
);
